>>> rtl/clc_pkg.sv
package clc_pkg;

  // Default geometry of the display memory.
  localparam int CHARS_PER_LINE_DEF = 64;
  localparam int LINE_COUNT_DEF     = 2;

  // Address layout: column in the low bits, line select above it.
  localparam int ADDR_W   = 7;
  localparam int COL_BITS = 6;
  localparam int LINE_BIT = 6;
  localparam int CHAR_W   = 8;
  localparam int OFFS_W   = 8;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Bus function codes as they arrive on the input channel.
  localparam logic [3:0] FUNC_DATA    = 4'd0;
  localparam logic [3:0] FUNC_CLEAR   = 4'd1;
  localparam logic [3:0] FUNC_HOME    = 4'd2;
  localparam logic [3:0] FUNC_ENTRY   = 4'd3;
  localparam logic [3:0] FUNC_DISPLAY = 4'd4;
  localparam logic [3:0] FUNC_SHIFT   = 4'd5;
  localparam logic [3:0] FUNC_FUNCSET = 4'd6;
  localparam logic [3:0] FUNC_CGRAM   = 4'd7;
  localparam logic [3:0] FUNC_DDRAM   = 4'd8;
  localparam logic [3:0] FUNC_READ    = 4'd9;

  // Internal operation codes after classification.
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP     = 4'd0;
  localparam op_t OP_WRITE   = 4'd1;
  localparam op_t OP_CLEAR   = 4'd2;
  localparam op_t OP_HOME    = 4'd3;
  localparam op_t OP_ENTRY   = 4'd4;
  localparam op_t OP_DISPLAY = 4'd5;
  localparam op_t OP_SHIFT   = 4'd6;
  localparam op_t OP_FUNCSET = 4'd7;
  localparam op_t OP_CGRAM   = 4'd8;
  localparam op_t OP_DDRAM   = 4'd9;
  localparam op_t OP_READ    = 4'd10;

  typedef struct packed {
    op_t               op;
    logic              increment;
    logic              shift_on_write;
    logic              display_on;
    logic              shift_display;
    logic              shift_right;
    logic              eight_bit_bus;
    logic              tall_font;
    logic              two_lines;
    logic [ADDR_W-1:0] ram_address;
    logic [CHAR_W-1:0] char_code;
  } cmd_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

>>> rtl/clc_front.sv
module clc_front
  import clc_pkg::*;
(
  input  logic              start,
  input  logic              queue_full,
  input  logic [3:0]        in_func,
  input  logic              in_increment,
  input  logic              in_shift_on_write,
  input  logic              in_display_on,
  input  logic              in_shift_display,
  input  logic              in_shift_right,
  input  logic              in_eight_bit_bus,
  input  logic              in_tall_font,
  input  logic              in_two_lines,
  input  logic [ADDR_W-1:0] in_ram_address,
  input  logic [CHAR_W-1:0] in_char_code,
  output logic              busy,
  output logic              push,
  output cmd_t              push_cmd
);

  op_t op;

  // A data byte of zero and the unused codes become a plain no-op.
  always_comb begin
    op = OP_NOP;
    unique case (in_func)
      FUNC_DATA:    op = (in_char_code != '0) ? OP_WRITE : OP_NOP;
      FUNC_CLEAR:   op = OP_CLEAR;
      FUNC_HOME:    op = OP_HOME;
      FUNC_ENTRY:   op = OP_ENTRY;
      FUNC_DISPLAY: op = OP_DISPLAY;
      FUNC_SHIFT:   op = OP_SHIFT;
      FUNC_FUNCSET: op = OP_FUNCSET;
      FUNC_CGRAM:   op = OP_CGRAM;
      FUNC_DDRAM:   op = OP_DDRAM;
      FUNC_READ:    op = OP_READ;
      default:      op = OP_NOP;
    endcase
  end

  assign busy = queue_full;
  assign push = start && !queue_full;

  assign push_cmd = '{
    op:             op,
    increment:      in_increment,
    shift_on_write: in_shift_on_write,
    display_on:     in_display_on,
    shift_display:  in_shift_display,
    shift_right:    in_shift_right,
    eight_bit_bus:  in_eight_bit_bus,
    tall_font:      in_tall_font,
    two_lines:      in_two_lines,
    ram_address:    in_ram_address,
    char_code:      in_char_code
  };

endmodule

>>> rtl/clc_queue.sv
module clc_queue
  import clc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output logic    full,
  output q_head_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.cmd   = slot_r[rd_ptr_r];

endmodule

>>> rtl/clc_back.sv
module clc_back
  import clc_pkg::*;
#(
  parameter int CHARS_PER_LINE = CHARS_PER_LINE_DEF,
  parameter int LINE_COUNT     = LINE_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  q_head_t                  head,
  output logic                     pop,
  output logic                     out_strobe,
  output logic [ADDR_W-1:0]        out_cursor_pos,
  output logic signed [OFFS_W-1:0] out_view_offset,
  output logic                     out_screen_enabled,
  output logic                     out_line_mode_two,
  output logic                     out_unsupported,
  output logic [CHAR_W-1:0]        out_read_char
);

  localparam int DEPTH     = LINE_COUNT * CHARS_PER_LINE;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int MEM_SLOTS = 1 << IDX_W;

  // Architectural state.
  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [OFFS_W-1:0] offset_r, offset_nxt;
  logic              move_up_r, move_up_nxt;
  logic              follow_r, follow_nxt;
  logic              screen_on_r, screen_on_nxt;
  logic              lines_two_r, lines_two_nxt;
  logic              bad_r, bad_nxt;

  // Display memory; an entry whose valid bit is clear reads as a blank.
  logic [CHAR_W-1:0]    mem [MEM_SLOTS];
  logic [MEM_SLOTS-1:0] vld_r;

  // Stage after execution, then the output register.
  logic                     s1_valid_r;
  logic [ADDR_W-1:0]        s1_cursor_r;
  logic [OFFS_W-1:0]        s1_offset_r;
  logic                     s1_screen_r;
  logic                     s1_lines_r;
  logic                     s1_bad_r;
  logic                     s1_is_read_r;
  logic                     s1_hit_r;
  logic [CHAR_W-1:0]        rd_data_r;

  logic                     out_strobe_r;
  logic [ADDR_W-1:0]        out_cursor_r;
  logic [OFFS_W-1:0]        out_offset_r;
  logic                     out_screen_r;
  logic                     out_lines_r;
  logic                     out_bad_r;
  logic [CHAR_W-1:0]        out_char_r;

  logic              exec;
  cmd_t              cmd;
  logic              wr_en, clr_en, is_read;
  logic              cur_in_ram, rd_in_ram;
  logic [IDX_W-1:0]  wr_idx, rd_idx;

  function automatic logic addr_in_ram(input logic [ADDR_W-1:0] addr);
    logic col_ok, line_ok;
    col_ok  = ({1'b0, addr[COL_BITS-1:0]} < (COL_BITS + 1)'(CHARS_PER_LINE));
    line_ok = (LINE_COUNT > 1) || !addr[LINE_BIT];
    return col_ok && line_ok;
  endfunction

  function automatic logic [IDX_W-1:0] addr_index(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W:0] full_idx;
    full_idx = addr[LINE_BIT] ? ((ADDR_W + 1)'(CHARS_PER_LINE) + (ADDR_W + 1)'(addr[COL_BITS-1:0]))
                              : (ADDR_W + 1)'(addr[COL_BITS-1:0]);
    return full_idx[IDX_W-1:0];
  endfunction

  assign exec       = head.valid;
  assign pop        = exec;
  assign cmd        = head.cmd;
  assign cur_in_ram = addr_in_ram(cursor_r);
  assign rd_in_ram  = addr_in_ram(cmd.ram_address);
  assign wr_idx     = addr_index(cursor_r);
  assign rd_idx     = addr_index(cmd.ram_address);

  always_comb begin
    cursor_nxt    = cursor_r;
    offset_nxt    = offset_r;
    move_up_nxt   = move_up_r;
    follow_nxt    = follow_r;
    screen_on_nxt = screen_on_r;
    lines_two_nxt = lines_two_r;
    bad_nxt       = bad_r;
    wr_en         = 1'b0;
    clr_en        = 1'b0;
    is_read       = 1'b0;
    if (exec) begin
      unique case (cmd.op)
        OP_WRITE: begin
          wr_en      = cur_in_ram;
          cursor_nxt = move_up_r ? cursor_r + 1'b1 : cursor_r - 1'b1;
          if (follow_r) begin
            offset_nxt = move_up_r ? offset_r + 1'b1 : offset_r - 1'b1;
          end
        end
        OP_CLEAR: begin
          clr_en     = 1'b1;
          cursor_nxt = '0;
          offset_nxt = '0;
        end
        OP_HOME: begin
          cursor_nxt = '0;
          offset_nxt = '0;
        end
        OP_ENTRY: begin
          move_up_nxt = cmd.increment;
          follow_nxt  = cmd.shift_on_write;
        end
        OP_DISPLAY: screen_on_nxt = cmd.display_on;
        OP_SHIFT: begin
          if (cmd.shift_display) begin
            offset_nxt = cmd.shift_right ? offset_r - 1'b1 : offset_r + 1'b1;
          end else begin
            cursor_nxt = cmd.shift_right ? cursor_r + 1'b1 : cursor_r - 1'b1;
          end
        end
        OP_FUNCSET: begin
          if (!cmd.eight_bit_bus || cmd.tall_font) begin
            bad_nxt = 1'b1;
          end
          lines_two_nxt = cmd.two_lines;
        end
        OP_CGRAM: bad_nxt = 1'b1;
        OP_DDRAM: cursor_nxt = cmd.ram_address;
        OP_READ:  is_read = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r     <= '0;
      offset_r     <= '0;
      move_up_r    <= 1'b1;
      follow_r     <= 1'b0;
      screen_on_r  <= 1'b1;
      lines_two_r  <= 1'b1;
      bad_r        <= 1'b0;
      vld_r        <= '0;
      s1_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      cursor_r     <= cursor_nxt;
      offset_r     <= offset_nxt;
      move_up_r    <= move_up_nxt;
      follow_r     <= follow_nxt;
      screen_on_r  <= screen_on_nxt;
      lines_two_r  <= lines_two_nxt;
      bad_r        <= bad_nxt;
      if (clr_en) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      s1_valid_r   <= exec;
      out_strobe_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= cmd.char_code;
    end
    rd_data_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    s1_cursor_r  <= cursor_nxt;
    s1_offset_r  <= offset_nxt;
    s1_screen_r  <= screen_on_nxt;
    s1_lines_r   <= lines_two_nxt && (LINE_COUNT > 1);
    s1_bad_r     <= bad_nxt;
    s1_is_read_r <= is_read;
    s1_hit_r     <= rd_in_ram && vld_r[rd_idx];
    out_cursor_r <= s1_cursor_r;
    out_offset_r <= s1_offset_r;
    out_screen_r <= s1_screen_r;
    out_lines_r  <= s1_lines_r;
    out_bad_r    <= s1_bad_r;
    out_char_r   <= !s1_is_read_r ? '0 : (s1_hit_r ? rd_data_r : BLANK_CHAR);
  end

  assign out_strobe         = out_strobe_r;
  assign out_cursor_pos     = out_cursor_r;
  assign out_view_offset    = out_offset_r;
  assign out_screen_enabled = out_screen_r;
  assign out_line_mode_two  = out_lines_r;
  assign out_unsupported    = out_bad_r;
  assign out_read_char      = out_char_r;

  a_strobe_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> ##1 out_strobe_r)
    else $error("result strobe missing two cycles after execution");

  a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && cmd.op == OP_CLEAR) |=> (cursor_r == '0 && offset_r == '0 && vld_r == '0))
    else $error("clear left cursor, offset or memory state behind");

  a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    bad_r |=> bad_r)
    else $error("unsupported flag dropped without reset");

  a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
    (LINE_COUNT < 2) |-> !out_lines_r)
    else $error("two-line mode reported on a one-line display");

endmodule

>>> rtl/char_lcd_controller.sv
// Character LCD controller, instruction subset of the usual character display scheme.
//
// Input channel: an item (one bus access: a data byte or an instruction,
// selected by in_func) is accepted at a rising edge where start is high and
// busy is low. The front end classifies the item and places it in a
// two-entry command queue; the back end takes one command per cycle from it.
// Result channel: one result per item, presented for exactly one cycle with
// out_strobe high. It carries the cursor, display offset and flags as they
// stand after the item, and the stored character for a read access.
// An item passes the queue, then the stage after execution and the output register.
// Throughput: one item per cycle; the back end retires a command every
// cycle, so the queue drains as fast as it fills and busy stays low.
// Clear does not walk the memory: the display memory has one valid bit per
// entry, and an entry whose bit is clear reads as a space.
// Reset (rst_n low at a clock edge) empties the queue, drops any result in
// flight, blanks the display memory and restores the power-on modes.
// The receiver cannot stall the result channel; every strobe is taken.
module char_lcd_controller
  import clc_pkg::*;
#(
  parameter int CHARS_PER_LINE = CHARS_PER_LINE_DEF,
  parameter int LINE_COUNT     = LINE_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [3:0]               in_func,
  input  logic                     in_increment,
  input  logic                     in_shift_on_write,
  input  logic                     in_display_on,
  input  logic                     in_shift_display,
  input  logic                     in_shift_right,
  input  logic                     in_eight_bit_bus,
  input  logic                     in_tall_font,
  input  logic                     in_two_lines,
  input  logic [ADDR_W-1:0]        in_ram_address,
  input  logic [CHAR_W-1:0]        in_char_code,
  output logic                     out_strobe,
  output logic [ADDR_W-1:0]        out_cursor_pos,
  output logic signed [OFFS_W-1:0] out_view_offset,
  output logic                     out_screen_enabled,
  output logic                     out_line_mode_two,
  output logic                     out_unsupported,
  output logic [CHAR_W-1:0]        out_read_char
);

  // Handshake between the front end and the queue.
  logic    queue_full;
  logic    push;
  cmd_t    push_cmd;

  // Queue head as seen by the back end, and the back end's take signal.
  q_head_t head;
  logic    pop;

  // The front end decodes the function code into an internal operation.
  // A data write of a zero byte and the unused function codes become no-ops
  // here, so the back end never has to look at the raw bus encoding.
  clc_front u_front (
    .start             (start),
    .queue_full        (queue_full),
    .in_func           (in_func),
    .in_increment      (in_increment),
    .in_shift_on_write (in_shift_on_write),
    .in_display_on     (in_display_on),
    .in_shift_display  (in_shift_display),
    .in_shift_right    (in_shift_right),
    .in_eight_bit_bus  (in_eight_bit_bus),
    .in_tall_font      (in_tall_font),
    .in_two_lines      (in_two_lines),
    .in_ram_address    (in_ram_address),
    .in_char_code      (in_char_code),
    .busy              (busy),
    .push              (push),
    .push_cmd          (push_cmd)
  );

  // The queue decouples acceptance from execution.
  clc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (queue_full),
    .head     (head)
  );

  // The back end owns the display memory and all mode state. It executes
  // one command per cycle, registers the memory read, then the result.
  clc_back #(
    .CHARS_PER_LINE (CHARS_PER_LINE),
    .LINE_COUNT     (LINE_COUNT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .out_strobe         (out_strobe),
    .out_cursor_pos     (out_cursor_pos),
    .out_view_offset    (out_view_offset),
    .out_screen_enabled (out_screen_enabled),
    .out_line_mode_two  (out_line_mode_two),
    .out_unsupported    (out_unsupported),
    .out_read_char      (out_read_char)
  );

endmodule

>>> bench/char_lcd_controller_tb.sv
`timescale 1ns / 100ps

// This testbench checks the character LCD controller against a shadow model kept inside it.
// A driver presents bus accesses (data bytes and instructions) in bursts with random gaps.
// A monitor watches the input handshake and applies each accepted access to the model.
// It then checks every result strobe against the oldest status that the model predicted.
module char_lcd_controller_tb;
  import clc_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 10;
  localparam int REPORT_LIMIT  = 10;
  localparam int RAM_DEPTH     = 1 << ADDR_W;

  // Function codes above FUNC_READ are unused. The block must leave its state alone for them.
  localparam logic [3:0] FUNC_SPARE_LO = FUNC_READ + 4'd1;
  localparam logic [3:0] FUNC_SPARE_HI = 4'hF;

  // One bus access as the driver presents it. The drain_first flag makes the driver
  // hold the access back until every result already owed has come out.
  typedef struct packed {
    logic              drain_first;
    logic [3:0]        func;
    logic              increment;
    logic              shift_on_write;
    logic              display_on;
    logic              shift_display;
    logic              shift_right;
    logic              eight_bit_bus;
    logic              tall_font;
    logic              two_lines;
    logic [ADDR_W-1:0] ram_address;
    logic [CHAR_W-1:0] char_code;
  } lcd_access_t;

  // Controller status reported after each access.
  typedef struct packed {
    logic [ADDR_W-1:0] cursor_pos;
    logic [OFFS_W-1:0] view_offset;
    logic              screen_enabled;
    logic              line_mode_two;
    logic              unsupported;
    logic [CHAR_W-1:0] read_char;
  } lcd_status_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;

  logic [3:0]        in_func           = '0;
  logic              in_increment      = 1'b0;
  logic              in_shift_on_write = 1'b0;
  logic              in_display_on     = 1'b0;
  logic              in_shift_display  = 1'b0;
  logic              in_shift_right    = 1'b0;
  logic              in_eight_bit_bus  = 1'b0;
  logic              in_tall_font      = 1'b0;
  logic              in_two_lines      = 1'b0;
  logic [ADDR_W-1:0] in_ram_address    = '0;
  logic [CHAR_W-1:0] in_char_code      = '0;

  logic                     out_strobe;
  logic [ADDR_W-1:0]        out_cursor_pos;
  logic signed [OFFS_W-1:0] out_view_offset;
  logic                     out_screen_enabled;
  logic                     out_line_mode_two;
  logic                     out_unsupported;
  logic [CHAR_W-1:0]        out_read_char;

  char_lcd_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_increment       (in_increment),
    .in_shift_on_write  (in_shift_on_write),
    .in_display_on      (in_display_on),
    .in_shift_display   (in_shift_display),
    .in_shift_right     (in_shift_right),
    .in_eight_bit_bus   (in_eight_bit_bus),
    .in_tall_font       (in_tall_font),
    .in_two_lines       (in_two_lines),
    .in_ram_address     (in_ram_address),
    .in_char_code       (in_char_code),
    .out_strobe         (out_strobe),
    .out_cursor_pos     (out_cursor_pos),
    .out_view_offset    (out_view_offset),
    .out_screen_enabled (out_screen_enabled),
    .out_line_mode_two  (out_line_mode_two),
    .out_unsupported    (out_unsupported),
    .out_read_char      (out_read_char)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Shadow model of the controller.
  // ------------------------------------------------------------------

  logic [CHAR_W-1:0] shadow_ram [RAM_DEPTH];
  logic [ADDR_W-1:0] shadow_cursor;
  logic [OFFS_W-1:0] shadow_offset;
  logic              shadow_move_up;
  logic              shadow_follow;
  logic              shadow_screen_on;
  logic              shadow_two_lines;
  logic              shadow_bad;

  // An address is backed by memory only if both its column and its line exist.
  // Writes to other addresses are dropped, and reads of them return a space.
  function automatic bit addr_stored(input logic [ADDR_W-1:0] addr);
    return (int'(addr[COL_BITS-1:0]) < CHARS_PER_LINE_DEF) &&
           (int'(addr[LINE_BIT]) < LINE_COUNT_DEF);
  endfunction

  // This function applies one access to the shadow state and returns the status
  // the block should report. The default geometry is 64 columns by 2 lines, so a
  // stored entry's index is simply its address.
  function automatic lcd_status_t lcd_apply_access(input lcd_access_t a);
    lcd_status_t s;
    s.read_char = '0;
    case (a.func)
      FUNC_DATA: begin
        if (a.char_code != '0) begin
          if (addr_stored(shadow_cursor)) shadow_ram[shadow_cursor] = a.char_code;
          shadow_cursor = shadow_move_up ? shadow_cursor + 7'd1 : shadow_cursor - 7'd1;
          if (shadow_follow)
            shadow_offset = shadow_move_up ? shadow_offset + 8'd1 : shadow_offset - 8'd1;
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < RAM_DEPTH; i++) shadow_ram[i] = BLANK_CHAR;
        shadow_cursor = '0;
        shadow_offset = '0;
      end
      FUNC_HOME: begin
        shadow_cursor = '0;
        shadow_offset = '0;
      end
      FUNC_ENTRY: begin
        shadow_move_up = a.increment;
        shadow_follow  = a.shift_on_write;
      end
      FUNC_DISPLAY: shadow_screen_on = a.display_on;
      FUNC_SHIFT: begin
        // A display shift to the right lowers the offset. A cursor shift to the right
        // raises the cursor.
        if (a.shift_display)
          shadow_offset = a.shift_right ? shadow_offset - 8'd1 : shadow_offset + 8'd1;
        else
          shadow_cursor = a.shift_right ? shadow_cursor + 7'd1 : shadow_cursor - 7'd1;
      end
      FUNC_FUNCSET: begin
        if (!a.eight_bit_bus || a.tall_font) shadow_bad = 1'b1;
        shadow_two_lines = a.two_lines;
      end
      FUNC_CGRAM: shadow_bad = 1'b1;
      FUNC_DDRAM: shadow_cursor = a.ram_address;
      FUNC_READ: s.read_char = addr_stored(a.ram_address) ? shadow_ram[a.ram_address] : BLANK_CHAR;
      default: ;
    endcase
    s.cursor_pos     = shadow_cursor;
    s.view_offset    = shadow_offset;
    s.screen_enabled = shadow_screen_on;
    s.line_mode_two  = shadow_two_lines && (LINE_COUNT_DEF > 1);
    s.unsupported    = shadow_bad;
    return s;
  endfunction

  // ------------------------------------------------------------------
  // Monitor: it predicts on the input handshake and checks on each result strobe.
  // ------------------------------------------------------------------

  lcd_status_t status_q[$];
  int          results_owed = 0;
  int          mismatches   = 0;

  // The result for an item that is accepted at this edge cannot legally appear at
  // the same edge. So the strobe is checked before the new prediction is queued.
  // results_owed changes only by nonblocking assignment. This way the driver
  // always reads the value from before the edge.
  always @(posedge clk) begin
    lcd_status_t want;
    lcd_status_t got;
    lcd_access_t seen;
    int          retired;
    int          taken;
    retired = 0;
    taken   = 0;
    if (!rst_n) begin
      for (int i = 0; i < RAM_DEPTH; i++) shadow_ram[i] = BLANK_CHAR;
      shadow_cursor    = '0;
      shadow_offset    = '0;
      shadow_move_up   = 1'b1;
      shadow_follow    = 1'b0;
      shadow_screen_on = 1'b1;
      shadow_two_lines = 1'b1;
      shadow_bad       = 1'b0;
      status_q.delete();
      results_owed <= 0;
    end else begin
      got = {out_cursor_pos, out_view_offset, out_screen_enabled, out_line_mode_two,
             out_unsupported, out_read_char};
      if (out_strobe !== 1'b0) begin
        if (out_strobe !== 1'b1 || status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result strobe=%b with no item outstanding", $realtime, out_strobe);
        end else begin
          want    = status_q.pop_front();
          retired = 1;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: expected cursor=%0d offset=%0d on=%b two=%b unsup=%b char=%h",
                       $realtime, want.cursor_pos, $signed(want.view_offset),
                       want.screen_enabled, want.line_mode_two, want.unsupported,
                       want.read_char);
              $display("%0t: actual   cursor=%0d offset=%0d on=%b two=%b unsup=%b char=%h",
                       $realtime, got.cursor_pos, $signed(got.view_offset),
                       got.screen_enabled, got.line_mode_two, got.unsupported,
                       got.read_char);
            end
          end
        end
      end
      if (start && !busy) begin
        seen = {1'b0, in_func, in_increment, in_shift_on_write, in_display_on,
                in_shift_display, in_shift_right, in_eight_bit_bus, in_tall_font,
                in_two_lines, in_ram_address, in_char_code};
        status_q.push_back(lcd_apply_access(seen));
        taken = 1;
      end
      results_owed <= results_owed + taken - retired;
    end
  end

  // ------------------------------------------------------------------
  // Driver: it takes accesses from the queue and sends them in bursts.
  // ------------------------------------------------------------------

  lcd_access_t pending_q[$];
  int          burst_left = 0;
  int          gap_left   = 0;

  // This function returns an access with the given function code. Every other field
  // is random, so the fields that the code ignores still toggle.
  function automatic lcd_access_t rand_access(input logic [3:0] f);
    lcd_access_t a;
    a.drain_first = 1'b0;
    a.func        = f;
    {a.increment, a.shift_on_write, a.display_on, a.shift_display, a.shift_right,
     a.eight_bit_bus, a.tall_font, a.two_lines} = 8'($urandom);
    a.ram_address = ADDR_W'($urandom);
    a.char_code   = CHAR_W'($urandom);
    return a;
  endfunction

  task automatic drive_access(input lcd_access_t a);
    in_func           <= a.func;
    in_increment      <= a.increment;
    in_shift_on_write <= a.shift_on_write;
    in_display_on     <= a.display_on;
    in_shift_display  <= a.shift_display;
    in_shift_right    <= a.shift_right;
    in_eight_bit_bus  <= a.eight_bit_bus;
    in_tall_font      <= a.tall_font;
    in_two_lines      <= a.two_lines;
    in_ram_address    <= a.ram_address;
    in_char_code      <= a.char_code;
  endtask

  // While the block is busy, the presented item stays on the ports untouched.
  // Otherwise the driver either idles, with junk on the data ports, or presents the next
  // access. An access marked drain_first waits until start is low and nothing
  // is owed. That way no accepted item is still in flight.
  // Each signal gets at most one nonblocking assignment per edge.
  always @(posedge clk) begin
    lcd_access_t next_access;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // The item is held until busy drops.
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
      drive_access(rand_access(4'($urandom)));
    end else if (pending_q.size() != 0 &&
                 (!pending_q[0].drain_first || (!start && results_owed == 0))) begin
      next_access = pending_q.pop_front();
      drive_access(next_access);
      start <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        // Most bursts are short with gaps of varied length. These gaps land on every
        // stage of the pipeline. A few long bursts run back to back with no gap.
        gap_left   = $urandom_range(1, 12);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 16);
      end
    end else begin
      start <= 1'b0;
      drive_access(rand_access(4'($urandom)));
    end
  end

  // ------------------------------------------------------------------
  // Stimulus, end of test and watchdog.
  // ------------------------------------------------------------------

  int random_items = 0;
  bit drain_next   = 1'b0;

  // This task queues an access. Accesses that the block merely ignores (unused codes
  // and zero data bytes) do not count toward the random total.
  task automatic add_access(input lcd_access_t a);
    a.drain_first = drain_next;
    drain_next    = 1'b0;
    pending_q.push_back(a);
    if (a.func <= FUNC_READ && !(a.func == FUNC_DATA && a.char_code == '0)) random_items++;
  endtask

  initial begin
    lcd_access_t a;
    int          kind;
    int          run_len;
    logic        run_dir;
    logic        run_disp;

    // The directed part comes first. It reads blank memory at both ends and checks
    // that a zero data byte is ignored. It covers cursor wrap in both directions,
    // offset wrap below zero, every instruction, and both unused code extremes.
    // It ends with the unsupported requests, because that flag is sticky.
    a = rand_access(FUNC_READ);    a.ram_address = 7'h00;  add_access(a);
    a = rand_access(FUNC_READ);    a.ram_address = 7'h7F;  add_access(a);
    a = rand_access(FUNC_DATA);    a.char_code = 8'h00;    add_access(a);
    a = rand_access(FUNC_DATA);    a.char_code = 8'hFF;    add_access(a);
    a = rand_access(FUNC_DATA);    a.char_code = 8'h01;    add_access(a);
    a = rand_access(FUNC_READ);    a.ram_address = 7'h00;  add_access(a);
    a = rand_access(FUNC_DDRAM);   a.ram_address = 7'h7F;  add_access(a);
    a = rand_access(FUNC_DATA);    a.char_code = 8'h80;    add_access(a);
    a = rand_access(FUNC_READ);    a.ram_address = 7'h7F;  add_access(a);
    a = rand_access(FUNC_SHIFT);   a.shift_display = 1'b0; a.shift_right = 1'b0; add_access(a);
    a = rand_access(FUNC_SHIFT);   a.shift_display = 1'b0; a.shift_right = 1'b1; add_access(a);
    a = rand_access(FUNC_ENTRY);   a.increment = 1'b0;     a.shift_on_write = 1'b1; add_access(a);
    a = rand_access(FUNC_DATA);    a.char_code = 8'h41;    add_access(a);
    a = rand_access(FUNC_SHIFT);   a.shift_display = 1'b1; a.shift_right = 1'b1; add_access(a);
    a = rand_access(FUNC_SHIFT);   a.shift_display = 1'b1; a.shift_right = 1'b0; add_access(a);
    a = rand_access(FUNC_ENTRY);   a.increment = 1'b1;     a.shift_on_write = 1'b0; add_access(a);
    a = rand_access(FUNC_DISPLAY); a.display_on = 1'b0;    add_access(a);
    a = rand_access(FUNC_DISPLAY); a.display_on = 1'b1;    add_access(a);
    a = rand_access(FUNC_FUNCSET);
    a.eight_bit_bus = 1'b1; a.tall_font = 1'b0; a.two_lines = 1'b0; add_access(a);
    a = rand_access(FUNC_FUNCSET);
    a.eight_bit_bus = 1'b1; a.tall_font = 1'b0; a.two_lines = 1'b1; add_access(a);
    a = rand_access(FUNC_HOME);                            add_access(a);
    a = rand_access(FUNC_SPARE_LO);                        add_access(a);
    a = rand_access(FUNC_SPARE_HI);                        add_access(a);
    a = rand_access(FUNC_CLEAR);                           add_access(a);
    a = rand_access(FUNC_READ);    a.ram_address = 7'h7F;  add_access(a);
    a = rand_access(FUNC_FUNCSET); a.eight_bit_bus = 1'b0; a.tall_font = 1'b1; add_access(a);
    a = rand_access(FUNC_CGRAM);                           add_access(a);

    // The random part is built from short, well-formed command sequences, and the
    // first one waits for a full drain. Now and then a later sequence also waits
    // for a drain, so the pipeline runs empty between accesses.
    random_items = 0;
    drain_next   = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 63) == 0) drain_next = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // Optionally move the cursor, write a run of characters, then read some back.
        if ($urandom_range(0, 1) == 1) add_access(rand_access(FUNC_DDRAM));
        repeat ($urandom_range(1, 20)) begin
          a = rand_access(FUNC_DATA);
          if ($urandom_range(0, 15) == 0) a.char_code = '0;
          add_access(a);
        end
        repeat ($urandom_range(0, 4)) add_access(rand_access(FUNC_READ));
      end else if (kind < 55) begin
        repeat ($urandom_range(1, 8)) add_access(rand_access(FUNC_READ));
      end else if (kind < 65) begin
        // A new entry mode, followed by writes that move the cursor and maybe the offset.
        add_access(rand_access(FUNC_ENTRY));
        repeat ($urandom_range(1, 12)) add_access(rand_access(FUNC_DATA));
      end else if (kind < 75) begin
        // Runs of shifts in one direction. The long runs carry the offset across
        // its signed limit.
        run_dir  = 1'($urandom);
        run_disp = 1'($urandom);
        run_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 140)
                                               : $urandom_range(1, 8);
        repeat (run_len) begin
          a = rand_access(FUNC_SHIFT);
          a.shift_display = run_disp;
          a.shift_right   = run_dir;
          add_access(a);
        end
      end else if (kind < 90) begin
        case ($urandom_range(0, 9))
          0:       add_access(rand_access(FUNC_CLEAR));
          1, 2:    add_access(rand_access(FUNC_HOME));
          3, 4:    add_access(rand_access(FUNC_DISPLAY));
          5, 6:    add_access(rand_access(FUNC_FUNCSET));
          7:       add_access(rand_access(FUNC_CGRAM));
          8:       add_access(rand_access(FUNC_DDRAM));
          default: add_access(rand_access(4'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI))));
        endcase
      end else begin
        add_access(rand_access(4'($urandom)));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The end condition is sampled at the falling edge, after all updates from the
    // rising edge have settled.
    while (pending_q.size() != 0 || start || results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS char_lcd_controller");
    end else begin
      $display("FAIL char_lcd_controller");
    end
    $finish;
  end

  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL char_lcd_controller");
      $finish;
    end
  end

endmodule

>>> filelist.f
rtl/clc_pkg.sv
rtl/clc_front.sv
rtl/clc_queue.sv
rtl/clc_back.sv
rtl/char_lcd_controller.sv
bench/char_lcd_controller_tb.sv
